// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and constants shared by the sorted-insert priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int SPQ_DEPTH = 16;

	localparam int ID_W   = 8;
	localparam int PRIO_W = 8;
	localparam int DUR_W  = 10;
	localparam int OCC_W  = 5;
	localparam int CAP_W  = 5;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		ACT_ENQ = 1'b0,
		ACT_DEQ = 1'b1
	} action_t;

	typedef enum logic {
		MODE_PRIO = 1'b0,
		MODE_DUR  = 1'b1
	} mode_t;

	typedef enum logic {
		REG_ORDER_MODE = 1'b0,
		REG_CAPACITY   = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [0:0]        action;
		logic [ID_W-1:0]   entry_id;
		logic [PRIO_W-1:0] entry_priority;
		logic [DUR_W-1:0]  entry_duration;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   out_id;
		logic [PRIO_W-1:0] out_priority;
		logic [DUR_W-1:0]  out_duration;
		logic [OCC_W-1:0]  occupancy;
	} out_item_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		logic [DUR_W-1:0]  dur;
	} entry_t;

	typedef struct packed {
		logic   insert;
		logic   remove;
		mode_t  mode;
		entry_t new_entry;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the entry
// being inserted, and shifts right on insert or left on removal.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      prev_run,
	input  entry_t    left_entry,
	input  logic      left_occ,
	input  entry_t    right_entry,
	input  logic      right_occ,
	output logic      run,
	output entry_t    entry,
	output logic      occ
);

	entry_t entry_q;
	logic   occ_q;
	logic   pass;

	always_comb begin
		if (ctl.mode == MODE_DUR) begin
			pass = occ_q && (entry_q.dur <= ctl.new_entry.dur);
		end else begin
			pass = occ_q && (entry_q.prio >= ctl.new_entry.prio);
		end
	end

	assign run   = prev_run && pass;
	assign entry = entry_q;
	assign occ   = occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.insert) begin
			if (!prev_run) begin
				occ_q <= left_occ;
			end else if (!pass) begin
				occ_q <= 1'b1;
			end
		end else if (ctl.remove) begin
			occ_q <= right_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (!prev_run) begin
				entry_q <= left_entry;
			end else if (!pass) begin
				entry_q <= ctl.new_entry;
			end
		end else if (ctl.remove) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== hw/rtl/sorted_insert_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_top
// Bounded sorted queue built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries an enqueue or dequeue.
//   Output channel (out_valid/out_stall/out_data) returns one result per
//   input transaction: status, the dequeued entry, and the occupancy.
//   out_valid rises in the cycle after input acceptance; throughput is one
//   transaction per cycle while not stalled: every cell compares its entry
//   with the new one in parallel and the chain shifts by one slot in the
//   same cycle; the ripple of the leading-run chain across DEPTH cells sets
//   the cycle time. When the receiver stalls, the result holds in the
//   output register and in_stall rises until it is taken.
//   Registers on the APB port: order_mode at 0x0, capacity at 0x4. Write
//   them only while the queue is idle.
//   Reset empties the queue, sets order_mode to 0 and capacity to 16; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_top
	import spq_pkg::*;
#(
	parameter int DEPTH = SPQ_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	mode_t            mode_q;
	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	out_item_t        out_data_q;

	logic             accept;
	logic             full;
	logic             empty;
	logic             cfg_wr;
	cell_ctl_t        ctl;
	out_item_t        result_d;

	logic   [DEPTH:0]   run;
	entry_t [DEPTH-1:0] cell_entry;
	logic   [DEPTH-1:0] cell_occ;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_PRIO;
			capacity_q <= CAP_W'(16);
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_ORDER_MODE: mode_q     <= mode_t'(pwdata[0]);
				REG_CAPACITY:   capacity_q <= pwdata[CAP_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_ORDER_MODE: prdata = APB_DW'(mode_q);
			REG_CAPACITY:   prdata = APB_DW'(capacity_q);
			default:        prdata = '0;
		endcase
	end

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign full  = (CMP_W'(count_q) >= CMP_W'(capacity_q)) ||
	               (CMP_W'(count_q) >= CMP_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		ctl.insert    = accept && (in_data.action == ACT_ENQ) && !full;
		ctl.remove    = accept && (in_data.action == ACT_DEQ) && !empty;
		ctl.mode      = mode_q;
		ctl.new_entry = '{id:   in_data.entry_id,
		                  prio: in_data.entry_priority,
		                  dur:  in_data.entry_duration};
	end

	assign run[0] = 1'b1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_entry;
		logic   left_occ;
		entry_t right_entry;
		logic   right_occ;

		if (i == 0) begin : g_head
			assign left_entry = ctl.new_entry;
			assign left_occ   = 1'b1;
		end else begin : g_body
			assign left_entry = cell_entry[i-1];
			assign left_occ   = cell_occ[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_entry = cell_entry[i];
			assign right_occ   = 1'b0;
		end else begin : g_mid
			assign right_entry = cell_entry[i+1];
			assign right_occ   = cell_occ[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_run   (run[i]),
			.left_entry (left_entry),
			.left_occ   (left_occ),
			.right_entry(right_entry),
			.right_occ  (right_occ),
			.run        (run[i+1]),
			.entry      (cell_entry[i]),
			.occ        (cell_occ[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.remove) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		result_d = '0;
		if (in_data.action == ACT_ENQ) begin
			if (full) begin
				result_d.status    = ST_FULL;
				result_d.occupancy = OCC_W'(count_q);
			end else begin
				result_d.status    = ST_DONE;
				result_d.occupancy = OCC_W'(count_q + CNT_W'(1));
			end
		end else if (empty) begin
			result_d.status = ST_EMPTY;
		end else begin
			result_d.status       = ST_DONE;
			result_d.out_id       = cell_entry[0].id;
			result_d.out_priority = cell_entry[0].prio;
			result_d.out_duration = cell_entry[0].dur;
			result_d.occupancy    = OCC_W'(count_q - CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== hw/rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted-insert priority queue, bound to the top.
// ----------------------------------------------------------------------------
module spq_checker
	import spq_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted transaction produced no result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_EMPTY |->
			out_data.occupancy == '0 && out_data.out_id == '0 &&
			out_data.out_priority == '0 && out_data.out_duration == '0)
		else $error("empty dequeue result not cleared");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_FULL |->
			out_data.out_id == '0 && out_data.out_priority == '0 &&
			out_data.out_duration == '0)
		else $error("dropped enqueue carries entry data");

endmodule

bind sorted_insert_priority_queue_top spq_checker u_spq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
